/* rtl/core/dssbd_pkg.sv */
// Shared constants, payload types and the segment table for the decimal
// seven-segment blanking driver. No dependencies.
package dssbd_pkg;

  localparam int unsigned DigitCount = 5;
  localparam int unsigned ValueW     = 16;
  localparam int unsigned PosW       = 3;
  localparam int unsigned SegW       = 7;
  localparam int unsigned BcdW       = 4;
  localparam int unsigned DigitsW    = DigitCount * BcdW;
  localparam int unsigned ProdW      = 2 * ValueW;

  // floor(x / 10) == (x * 0xCCCD) >> 19 for every 16-bit x
  localparam logic [ValueW-1:0] Recip10    = 16'hCCCD;
  localparam int unsigned       RecipShift = 19;

  typedef struct packed {
    logic [ValueW-1:0]  quo;
    logic [DigitsW-1:0] digits;
  } div_t;

  function automatic logic [SegW-1:0] seg_code(input logic [BcdW-1:0] d);
    logic [SegW-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h47;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/decimal_seven_segment_blanking_driver_core.sv */
// Path: an accepted item passes through the 5 divide-by-ten stages, then the
// output register in the serializer, which gives the first digit result.
// Output: the output stage sends one digit result per cycle while out_ready_i
// is high; up to 5 more items queue in the divide stages.
// Reset: asynchronous, active low; clears all valid bits, payload is kept.
module decimal_seven_segment_blanking_driver_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dssbd_pkg::ValueW-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [dssbd_pkg::PosW-1:0]   position_o,
  output logic [dssbd_pkg::SegW-1:0]   segments_o,
  output logic                         last_o
);

  logic            stg_valid [dssbd_pkg::DigitCount+1];
  logic            stg_ready [dssbd_pkg::DigitCount+1];
  dssbd_pkg::div_t stg_data  [dssbd_pkg::DigitCount+1];

  assign stg_valid[0]       = in_valid_i;
  assign in_ready_o         = stg_ready[0];
  assign stg_data[0].quo    = value_i;
  assign stg_data[0].digits = '0;

  for (genvar g = 0; g < dssbd_pkg::DigitCount; g++) begin : g_stage
    dssbd_digit_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[g]),
      .ready_o (stg_ready[g]),
      .data_i  (stg_data[g]),
      .valid_o (stg_valid[g+1]),
      .ready_i (stg_ready[g+1]),
      .data_o  (stg_data[g+1])
    );
  end

  dssbd_serializer u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (stg_valid[dssbd_pkg::DigitCount]),
    .ready_o    (stg_ready[dssbd_pkg::DigitCount]),
    .digits_i   (stg_data[dssbd_pkg::DigitCount].digits),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .position_o (position_o),
    .segments_o (segments_o),
    .last_o     (last_o)
  );

endmodule

/* rtl/core/dssbd_digit_stage.sv */
// One pipeline stage: divides the running quotient by ten and shifts the
// remainder digit into the top of the digit vector. Uses dssbd_pkg.
module dssbd_digit_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  dssbd_pkg::div_t   data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output dssbd_pkg::div_t   data_o
);

  logic                           valid_q, valid_d;
  dssbd_pkg::div_t                data_q, data_d;
  logic [dssbd_pkg::ProdW-1:0]    prod;
  logic [dssbd_pkg::ValueW-1:0]   quo_next;
  logic [dssbd_pkg::ValueW-1:0]   rem_full;
  logic [dssbd_pkg::BcdW-1:0]     rem;
  logic [dssbd_pkg::DigitsW+dssbd_pkg::BcdW-1:0] digits_ext;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    prod       = {{dssbd_pkg::ValueW{1'b0}}, data_i.quo}
               * {{dssbd_pkg::ValueW{1'b0}}, dssbd_pkg::Recip10};
    quo_next   = dssbd_pkg::ValueW'(prod >> dssbd_pkg::RecipShift);
    rem_full   = data_i.quo - ((quo_next << 3) + (quo_next << 1));
    rem        = rem_full[dssbd_pkg::BcdW-1:0];
    digits_ext = {rem, data_i.digits};
    data_d.quo    = quo_next;
    data_d.digits = digits_ext[dssbd_pkg::DigitsW+dssbd_pkg::BcdW-1:dssbd_pkg::BcdW];
  end

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/dssbd_serializer.sv */
// Output stage: holds one item's digits; sends one digit result per cycle
// when ready_i is high, most significant first, with leading-zero blanking. Uses dssbd_pkg.
module dssbd_serializer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [dssbd_pkg::DigitsW-1:0] digits_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [dssbd_pkg::PosW-1:0]    position_o,
  output logic [dssbd_pkg::SegW-1:0]    segments_o,
  output logic                          last_o
);

  logic                          valid_q, valid_d;
  logic [dssbd_pkg::DigitsW-1:0] digits_q, digits_d;
  logic [dssbd_pkg::PosW-1:0]    pos_q, pos_d;
  logic                          seen_q, seen_d;
  logic [dssbd_pkg::BcdW-1:0]    cur;
  logic                          lit;
  logic                          last;
  logic                          fire;
  logic                          load;

  assign cur  = digits_q[dssbd_pkg::DigitsW-1 -: dssbd_pkg::BcdW];
  assign lit  = seen_q || (cur != '0);
  assign last = (pos_q == dssbd_pkg::PosW'(dssbd_pkg::DigitCount));
  assign fire = valid_q && ready_i;
  assign ready_o = !valid_q || (ready_i && last);
  assign load = valid_i && ready_o;

  always_comb begin
    valid_d  = valid_q;
    digits_d = digits_q;
    pos_d    = pos_q;
    seen_d   = seen_q;
    if (load) begin
      valid_d  = 1'b1;
      digits_d = digits_i;
      pos_d    = dssbd_pkg::PosW'(1);
      seen_d   = 1'b0;
    end else if (fire) begin
      if (last) begin
        valid_d = 1'b0;
      end
      digits_d = digits_q << dssbd_pkg::BcdW;
      pos_d    = pos_q + dssbd_pkg::PosW'(1);
      seen_d   = lit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= dssbd_pkg::PosW'(1);
      seen_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pos_q   <= pos_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
  end

  assign valid_o    = valid_q;
  assign position_o = pos_q;
  assign segments_o = lit ? dssbd_pkg::seg_code(cur) : '0;
  assign last_o     = last;

endmodule

/* rtl/core/dssbd_checker.sv */
// Port-level checks for decimal_seven_segment_blanking_driver_core, bound
// to the top level below. Uses dssbd_pkg.
module dssbd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [dssbd_pkg::PosW-1:0]   position_o,
  input logic [dssbd_pkg::SegW-1:0]   segments_o,
  input logic                         last_o
);

  localparam logic [dssbd_pkg::PosW-1:0] LastPos = dssbd_pkg::PosW'(dssbd_pkg::DigitCount);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(position_o)
      && $stable(segments_o) && $stable(last_o))
    else $error("output item changed while stalled");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      out_valid_o && position_o == $past(position_o) + dssbd_pkg::PosW'(1))
    else $error("digit results not consecutive");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (position_o == LastPos)))
    else $error("last flag does not match final position");

  a_first_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=>
      !out_valid_o || position_o == dssbd_pkg::PosW'(1))
    else $error("new item does not start at position one");

  a_no_reblank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o && segments_o != '0 |=> segments_o != '0)
    else $error("digit blanked after a lit digit");

endmodule

bind decimal_seven_segment_blanking_driver_core dssbd_checker u_dssbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .position_o  (position_o),
  .segments_o  (segments_o),
  .last_o      (last_o)
);

/* dv/dssbd_digit_checker.sv */
// Scoreboard for the decimal seven-segment blanking driver: predicts the digit
// results of each accepted value and compares them in order with the output.
// Depends on dssbd_pkg for widths and the digit count.
module dssbd_digit_checker
  import dssbd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [ValueW-1:0] value_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [PosW-1:0]   position_i,
  input  logic [SegW-1:0]   segments_i,
  input  logic              last_i,
  output int                mismatch_cnt_o,
  output int                pending_o
);

  typedef struct packed {
    logic [PosW-1:0] position;
    logic [SegW-1:0] segments;
    logic            last;
  } digit_result_t;

  localparam logic [SegW-1:0] Glyph [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h47, 7'h7F, 7'h6F
  };

  digit_result_t digits_q [$];

  initial begin
    mismatch_cnt_o = 0;
    pending_o      = 0;
  end

  // most significant digit first, zeros ahead of the first nonzero digit dark
  task automatic queue_digits(input logic [ValueW-1:0] value);
    int unsigned   rest;
    int unsigned   dec [DigitCount];
    int unsigned   d;
    bit            lit;
    digit_result_t r;
    rest = value;
    lit  = 1'b0;
    for (int k = 0; k < DigitCount; k++) begin
      dec[k] = rest % 10;
      rest   = rest / 10;
    end
    for (int k = 0; k < DigitCount; k++) begin
      d = dec[DigitCount-1-k];
      if (d != 0) lit = 1'b1;
      r.position = PosW'(k + 1);
      r.segments = lit ? Glyph[d] : '0;
      r.last     = (k == DigitCount - 1);
      digits_q.push_back(r);
    end
  endtask

  always @(posedge clk_i) begin
    digit_result_t want;
    digit_result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) queue_digits(value_i);
      if (out_valid_i && out_ready_i) begin
        got = '{position: position_i, segments: segments_i, last: last_i};
        if (digits_q.size() == 0) begin
          if (mismatch_cnt_o < 10)
            $display("unexpected item: pos %0d seg %02h last %0b",
                     got.position, got.segments, got.last);
          mismatch_cnt_o++;
        end else begin
          want = digits_q.pop_front();
          if (got != want) begin
            if (mismatch_cnt_o < 10)
              $display("mismatch: exp pos %0d seg %02h last %0b, got pos %0d seg %02h last %0b",
                       want.position, want.segments, want.last,
                       got.position, got.segments, got.last);
            mismatch_cnt_o++;
          end
        end
      end
      pending_o = digits_q.size();
    end
  end

endmodule

/* dv/decimal_seven_segment_blanking_driver_core_tb.sv */
// Testbench top for the decimal seven-segment blanking driver: drives values
// with random gaps and output stalls, gives the verdict.
// Depends on dssbd_pkg, the core and dssbd_digit_checker.
module decimal_seven_segment_blanking_driver_core_tb;
  import dssbd_pkg::*;

  localparam int StallLimit = 1000;
  localparam int RandomItems = 128;
  localparam int CalmFrom = 104;
  localparam int unsigned EdgeValues [22] = '{
    0, 1, 9, 10, 7, 77, 100, 1000, 10000, 65535, 32768, 32767, 21845, 43690,
    10101, 7070, 50000, 60000, 12345, 9999, 40096, 10007
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [ValueW-1:0] value_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [PosW-1:0]   position_o;
  logic [SegW-1:0]   segments_o;
  logic              last_o;
  int                mismatches;
  int                pending;
  int                quiet_cycles = 0;
  bit                calm = 1'b0;

  always #1 clk_i = ~clk_i;

  decimal_seven_segment_blanking_driver_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .position_o (position_o),
    .segments_o (segments_o),
    .last_o     (last_o)
  );

  dssbd_digit_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .value_i       (value_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .position_i    (position_o),
    .segments_i    (segments_o),
    .last_i        (last_o),
    .mismatch_cnt_o(mismatches),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("[decimal_seven_segment_blanking_driver_core] ERROR");
      $finish;
    end
  end

  // output stalls
  initial begin
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_value(input logic [ValueW-1:0] v);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic sender_gap();
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 15);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // mix of full range, short numbers and numbers with inner zeros
  function automatic logic [ValueW-1:0] pick_value();
    int unsigned v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 65535);
      1: v = $urandom_range(0, 9);
      2: v = $urandom_range(10, 9999);
      default: begin
        v = 0;
        for (int k = 0; k < 5; k++)
          v = v * 10 + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 9));
        if (v > 65535) v = v - 40000;
      end
    endcase
    return ValueW'(v);
  endfunction

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    value_i    = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (EdgeValues[i]) begin
      send_value(ValueW'(EdgeValues[i]));
      if (i % 4 == 3) sender_gap();
    end
    drain();

    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 2) drain();
      if (i >= CalmFrom) calm = 1'b1;
      sender_gap();
      send_value(pick_value());
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0)
      $display("[decimal_seven_segment_blanking_driver_core] OK");
    else
      $display("[decimal_seven_segment_blanking_driver_core] ERROR");
    $finish;
  end

endmodule

/* decimal_seven_segment_blanking_driver_core.f */
rtl/core/dssbd_pkg.sv
rtl/core/dssbd_digit_stage.sv
rtl/core/dssbd_serializer.sv
rtl/core/decimal_seven_segment_blanking_driver_core.sv
rtl/core/dssbd_checker.sv
dv/dssbd_digit_checker.sv
dv/decimal_seven_segment_blanking_driver_core_tb.sv
